>>> rtl/core/kra_pkg.sv
// shared types and constants for the keyed rating accumulator
package kra_pkg;

    localparam int TABLE_DEPTH = 32768;
    localparam int SLOT_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = SLOT_W + 1;
    localparam int KEY_W = 31;
    localparam int SUM_W = 32;
    localparam int COUNT_W = 24;
    localparam int TOTAL_W = 32;
    localparam int RATING_W = 8;
    localparam int REG_W = 16;
    localparam int STATUS_W = 3;
    localparam int OUT_SLOT_W = 15;
    localparam int ENTRY_W = KEY_W + SUM_W + COUNT_W;

    localparam logic [REG_W-1:0] MODULUS_RESET = 16'd27997;
    localparam logic [REG_W-1:0] SLOTS_RESET = 16'd28000;

    localparam logic CMD_ADD = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic REG_MODULUS = 1'b0;
    localparam logic REG_SLOTS = 1'b1;

    localparam logic [STATUS_W-1:0] ST_IGNORED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ACCUM = 3'd1;
    localparam logic [STATUS_W-1:0] ST_INSERT = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FOUND = 3'd4;
    localparam logic [STATUS_W-1:0] ST_MISSING = 3'd5;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_RED,
        S_READ,
        S_WAIT,
        S_CHECK,
        S_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic clear_step;
        logic load;
        logic mod_start;
        logic red_start;
        logic take_home;
        logic issue_read;
        logic advance;
        logic write_insert;
        logic write_accum;
        logic set_result;
        logic [STATUS_W-1:0] result_status;
        logic result_from_entry;
        logic result_home;
    } kra_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_done;
        logic key_zero;
        logic cmd_query;
        logic div_busy;
        logic slot_valid;
        logic key_match;
        logic probe_done;
    } kra_stat_t;

endpackage

>>> rtl/core/kra_if.sv
// valid/ready channel interfaces for items and results
interface kra_in_if
    import kra_pkg::*;
    ();
    logic valid;
    logic ready;
    logic cmd;
    logic [KEY_W-1:0] movie_id;
    logic [RATING_W-1:0] rating;
    modport source (output valid, cmd, movie_id, rating, input ready);
    modport sink (input valid, cmd, movie_id, rating, output ready);
endinterface

interface kra_out_if
    import kra_pkg::*;
    ();
    logic valid;
    logic ready;
    logic [STATUS_W-1:0] status;
    logic [OUT_SLOT_W-1:0] slot;
    logic [SUM_W-1:0] rating_sum;
    logic [COUNT_W-1:0] rating_count;
    logic [TOTAL_W-1:0] total_ratings;
    modport source (output valid, status, slot, rating_sum, rating_count, total_ratings,
                    input ready);
    modport sink (input valid, status, slot, rating_sum, rating_count, total_ratings,
                  output ready);
endinterface

>>> rtl/core/kra_ram.sv
// generic single port ram with registered read
module kra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

>>> rtl/core/kra_div.sv
// bit serial remainder unit, one quotient bit per cycle
module kra_div
    import kra_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [KEY_W-1:0] dividend,
    input  logic [REG_W-1:0] divisor,
    output logic             busy,
    output logic [REG_W-1:0] remainder
);
    localparam int STEP_W = $clog2(KEY_W + 1);

    logic [STEP_W-1:0] step_reg, step_next;
    logic [KEY_W-1:0] shift_reg, shift_next;
    logic [REG_W:0] rem_reg, rem_next;
    logic [REG_W-1:0] dvs_reg, dvs_next;
    logic [REG_W:0] trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    always_comb
    begin
        step_next = step_reg;
        shift_next = shift_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        trial = {rem_reg[REG_W-1:0], shift_reg[KEY_W-1]};
        if (start)
        begin
            step_next = STEP_W'(KEY_W);
            shift_next = dividend;
            rem_next = '0;
            dvs_next = divisor;
        end
        else if (step_reg != '0)
        begin
            step_next = step_reg - 1'b1;
            shift_next = {shift_reg[KEY_W-2:0], 1'b0};
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = trial - {1'b0, dvs_reg};
            end
            else
            begin
                rem_next = trial;
            end
        end
    end

    assign busy = (step_reg != '0);
    assign remainder = rem_reg[REG_W-1:0];
endmodule

>>> rtl/core/kra_datapath.sv
// table memory, probe address, saturating arithmetic and result register
module kra_datapath
    import kra_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  kra_cmd_t       ctl,
    output kra_stat_t      sts,
    input  logic           cfg_we,
    input  logic           cfg_index,
    input  logic [REG_W-1:0] cfg_data,
    input  logic           in_cmd,
    input  logic [KEY_W-1:0] in_key,
    input  logic [RATING_W-1:0] in_rating,
    output logic [STATUS_W-1:0] res_status,
    output logic [OUT_SLOT_W-1:0] res_slot,
    output logic [SUM_W-1:0] res_sum,
    output logic [COUNT_W-1:0] res_count,
    output logic [TOTAL_W-1:0] res_total
);
    logic [REG_W-1:0] modulus_reg;
    logic [REG_W-1:0] slots_reg;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [SLOT_W-1:0] clear_reg;
    logic cmd_reg;
    logic [KEY_W-1:0] key_reg;
    logic [RATING_W-1:0] rating_reg;
    logic [CNT_W-1:0] n_reg;
    logic [SLOT_W-1:0] home_reg;
    logic [SLOT_W-1:0] idx_reg;
    logic [CNT_W-1:0] probes_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [OUT_SLOT_W-1:0] slot_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [COUNT_W-1:0] count_reg;

    logic [CNT_W-1:0] n_eff;
    logic [REG_W-1:0] mod_eff;
    logic [REG_W-1:0] rem;
    logic div_start;
    logic [KEY_W-1:0] div_dividend;
    logic [REG_W-1:0] div_divisor;
    logic div_busy;

    logic valid_we, valid_wdata, valid_rdata;
    logic [SLOT_W-1:0] ram_addr;
    logic entry_we;
    logic [ENTRY_W-1:0] entry_wdata, entry_rdata;
    logic [KEY_W-1:0] e_key;
    logic [SUM_W-1:0] e_sum, acc_sum;
    logic [COUNT_W-1:0] e_count, acc_count;
    logic [SUM_W:0] sum_wide;
    logic [SLOT_W-1:0] idx_inc;

    always_comb
    begin
        if (slots_reg == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (CNT_W'(slots_reg) > CNT_W'(TABLE_DEPTH))
        begin
            n_eff = CNT_W'(TABLE_DEPTH);
        end
        else
        begin
            n_eff = CNT_W'(slots_reg);
        end
        mod_eff = (modulus_reg == '0) ? REG_W'(1) : modulus_reg;
    end

    // first pass: key mod modulus, second pass: that mod slot count
    assign div_start = ctl.mod_start | ctl.red_start;
    assign div_dividend = ctl.mod_start ? key_reg : KEY_W'(rem);
    assign div_divisor = ctl.mod_start ? mod_eff : REG_W'(n_reg);

    kra_div u_div (
        .clk(clk),
        .rst_n(rst_n),
        .start(div_start),
        .dividend(div_dividend),
        .divisor(div_divisor),
        .busy(div_busy),
        .remainder(rem)
    );

    assign ram_addr = ctl.clear_step ? clear_reg : idx_reg;
    assign valid_we = ctl.clear_step | ctl.write_insert;
    assign valid_wdata = ctl.write_insert;
    assign {e_key, e_sum, e_count} = entry_rdata;
    assign sum_wide = {1'b0, e_sum} + (SUM_W + 1)'(rating_reg);
    assign acc_sum = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
    assign acc_count = (e_count == '1) ? e_count : e_count + 1'b1;
    assign entry_we = ctl.write_insert | ctl.write_accum;
    assign entry_wdata = ctl.write_insert
        ? {key_reg, SUM_W'(rating_reg), COUNT_W'(1)}
        : {key_reg, acc_sum, acc_count};

    kra_ram #(.WIDTH(1), .DEPTH(TABLE_DEPTH)) u_valid (
        .clk(clk),
        .we(valid_we),
        .addr(ram_addr),
        .wdata(valid_wdata),
        .rdata(valid_rdata)
    );

    kra_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_entry (
        .clk(clk),
        .we(entry_we),
        .addr(ram_addr),
        .wdata(entry_wdata),
        .rdata(entry_rdata)
    );

    assign idx_inc = (CNT_W'(idx_reg) + 1'b1 >= n_reg) ? '0 : idx_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= MODULUS_RESET;
            slots_reg <= SLOTS_RESET;
            total_reg <= '0;
            clear_reg <= '0;
        end
        else
        begin
            if (cfg_we && cfg_index == REG_MODULUS)
            begin
                modulus_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == REG_SLOTS)
            begin
                slots_reg <= cfg_data;
            end
            total_reg <= total_next;
            if (ctl.clear_step)
            begin
                clear_reg <= clear_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        total_next = total_reg;
        if (entry_we && total_reg != '1)
        begin
            total_next = total_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg <= in_cmd;
            key_reg <= in_key;
            rating_reg <= in_rating;
            n_reg <= n_eff;
        end
        if (ctl.take_home)
        begin
            home_reg <= SLOT_W'(rem);
            idx_reg <= SLOT_W'(rem);
            probes_reg <= '0;
        end
        if (ctl.advance)
        begin
            idx_reg <= idx_inc;
            probes_reg <= probes_reg + 1'b1;
        end
        if (ctl.set_result)
        begin
            status_reg <= ctl.result_status;
            slot_reg <= '0;
            sum_reg <= '0;
            count_reg <= '0;
            if (ctl.result_status != ST_IGNORED)
            begin
                slot_reg <= OUT_SLOT_W'(ctl.result_home ? home_reg : idx_reg);
            end
            if (ctl.write_insert)
            begin
                sum_reg <= SUM_W'(rating_reg);
                count_reg <= COUNT_W'(1);
            end
            else if (ctl.write_accum)
            begin
                sum_reg <= acc_sum;
                count_reg <= acc_count;
            end
            else if (ctl.result_from_entry)
            begin
                sum_reg <= e_sum;
                count_reg <= e_count;
            end
        end
    end

    assign sts.clear_done = (clear_reg == '1);
    assign sts.key_zero = (key_reg == '0);
    assign sts.cmd_query = (cmd_reg == CMD_QUERY);
    assign sts.div_busy = div_busy;
    assign sts.slot_valid = valid_rdata;
    assign sts.key_match = (e_key == key_reg);
    assign sts.probe_done = (probes_reg + 1'b1 >= n_reg);

    assign res_status = status_reg;
    assign res_slot = slot_reg;
    assign res_sum = sum_reg;
    assign res_count = count_reg;
    assign res_total = total_reg;
endmodule

>>> rtl/core/kra_ctrl.sv
// sequencer for clearing, hashing, probing and result handoff
module kra_ctrl
    import kra_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  kra_stat_t sts,
    output kra_cmd_t  ctl
);
    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                ctl.clear_step = 1'b1;
                if (sts.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.load = 1'b1;
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                if (sts.key_zero)
                begin
                    ctl.set_result = 1'b1;
                    ctl.result_status = ST_IGNORED;
                    state_next = S_OUT;
                end
                else
                begin
                    ctl.mod_start = 1'b1;
                    state_next = S_RED;
                end
            end
            S_RED:
            begin
                if (!sts.div_busy)
                begin
                    ctl.red_start = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                if (!sts.div_busy)
                begin
                    ctl.take_home = 1'b1;
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                // memory read of the probe slot in flight
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                state_next = S_OUT;
                ctl.set_result = 1'b1;
                if (!sts.slot_valid)
                begin
                    if (sts.cmd_query)
                    begin
                        ctl.result_status = ST_MISSING;
                    end
                    else
                    begin
                        ctl.result_status = ST_INSERT;
                        ctl.write_insert = 1'b1;
                    end
                end
                else if (sts.key_match)
                begin
                    ctl.result_from_entry = 1'b1;
                    if (sts.cmd_query)
                    begin
                        ctl.result_status = ST_FOUND;
                    end
                    else
                    begin
                        ctl.result_status = ST_ACCUM;
                        ctl.write_accum = 1'b1;
                    end
                end
                else if (sts.probe_done)
                begin
                    ctl.result_home = 1'b1;
                    ctl.result_status = sts.cmd_query ? ST_MISSING : ST_FULL;
                end
                else
                begin
                    ctl.set_result = 1'b0;
                    ctl.advance = 1'b1;
                    state_next = S_WAIT;
                end
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

>>> rtl/core/keyed_rating_accumulator_top.sv
// keyed rating accumulator: hashed table of per-key rating sums and counts
// each transaction runs two 31 step bit serial remainders, then a read and a check per probed slot
// throughput: one transaction at a time; the next is taken after the result is delivered
// key zero skips the remainders and the table and returns status ignored
// after reset a clearing pass over all TABLE_DEPTH slots runs before the first transaction
// rst_n clears the configuration registers to their defaults and the total count to zero
module keyed_rating_accumulator_top
    import kra_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    kra_in_if.sink           in_ch,
    kra_out_if.source        out_ch,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [REG_W-1:0] cfg_data
);
    kra_cmd_t ctl;
    kra_stat_t sts;

    kra_ctrl u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_ch.valid),
        .in_ready(in_ch.ready),
        .out_valid(out_ch.valid),
        .out_ready(out_ch.ready),
        .sts(sts),
        .ctl(ctl)
    );

    kra_datapath u_dp (
        .clk(clk),
        .rst_n(rst_n),
        .ctl(ctl),
        .sts(sts),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_cmd(in_ch.cmd),
        .in_key(in_ch.movie_id),
        .in_rating(in_ch.rating),
        .res_status(out_ch.status),
        .res_slot(out_ch.slot),
        .res_sum(out_ch.rating_sum),
        .res_count(out_ch.rating_count),
        .res_total(out_ch.total_ratings)
    );
endmodule
